@@ rtl/core/rmcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rmcc_pkg;

  localparam int QueueDepth = 4;

  localparam int CmdW     = 4;
  localparam int ValueW   = 8;
  localparam int SpeedW   = 7;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  // Event kinds carried on the input tuser.
  localparam logic [CmdW-1:0] CMD_TICK    = 4'd0;
  localparam logic [CmdW-1:0] CMD_SENSOR  = 4'd1;
  localparam logic [CmdW-1:0] CMD_PAUSE   = 4'd2;
  localparam logic [CmdW-1:0] CMD_RESUME  = 4'd3;
  localparam logic [CmdW-1:0] CMD_LEFT    = 4'd4;
  localparam logic [CmdW-1:0] CMD_RIGHT   = 4'd5;
  localparam logic [CmdW-1:0] CMD_FORWARD = 4'd6;
  localparam logic [CmdW-1:0] CMD_REVERSE = 4'd7;
  localparam logic [CmdW-1:0] CMD_ACCEL   = 4'd8;
  localparam logic [CmdW-1:0] CMD_DECEL   = 4'd9;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DECEL_REFERENCE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STOP_THRESHOLD  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED       = 2'd3;

  localparam logic [ValueW-1:0] ACCEL_THRESHOLD_RST = 8'd20;
  localparam logic [ValueW-1:0] DECEL_REFERENCE_RST = 8'd12;
  localparam logic [ValueW-1:0] STOP_THRESHOLD_RST  = 8'd8;
  localparam logic [SpeedW-1:0] MAX_SPEED_RST       = 7'd127;

  typedef struct packed {
    logic [ValueW-1:0] accel_threshold;
    logic [ValueW-1:0] decel_reference;
    logic [ValueW-1:0] stop_threshold;
    logic [SpeedW-1:0] max_speed;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_PAUSE,
    OP_RESUME,
    OP_MOTION,
    OP_SPEED_UP,
    OP_SLOW_DOWN,
    OP_ERROR
  } op_t;

  // For speed up and slow down the amount travels in lspd.
  typedef struct packed {
    op_t               op;
    logic              lrev;
    logic              rrev;
    logic [ValueW-1:0] lspd;
    logic [ValueW-1:0] rspd;
  } entry_t;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic              motor_select;
    logic              reverse;
    logic              error;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/rmcc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rmcc_front (
  input  rmcc_pkg::cfg_t                  cfg,
  input  logic [rmcc_pkg::CmdW-1:0]       cmd,
  input  logic [rmcc_pkg::ValueW-1:0]     value,
  output logic                            enq,
  output rmcc_pkg::entry_t                ent
);
  import rmcc_pkg::*;

  always_comb begin
    enq = 1'b1;
    ent = '0;
    ent.op = OP_ERROR;
    unique case (cmd)
      CMD_TICK:   ent.op = OP_TICK;
      CMD_PAUSE:  ent.op = OP_PAUSE;
      CMD_RESUME: ent.op = OP_RESUME;
      CMD_SENSOR: begin
        // Accelerate test first, then the deceleration band, then stop.
        if (value >= cfg.accel_threshold) begin
          ent.op = OP_SPEED_UP;
          ent.lspd = (value > cfg.decel_reference) ? value - cfg.decel_reference : '0;
        end else if (value <= cfg.decel_reference && value >= cfg.stop_threshold) begin
          ent.op = OP_SLOW_DOWN;
          ent.lspd = cfg.decel_reference - value;
        end else if (value < cfg.stop_threshold) begin
          ent.op = OP_MOTION;
        end else begin
          // A distance in none of the bands changes nothing.
          enq = 1'b0;
        end
      end
      CMD_LEFT: begin
        ent.op = OP_MOTION;
        ent.lrev = 1'b1;
        ent.lspd = {1'b0, value[ValueW-1:1]};
        ent.rspd = value;
      end
      CMD_RIGHT: begin
        ent.op = OP_MOTION;
        ent.rrev = 1'b1;
        ent.lspd = value;
        ent.rspd = {1'b0, value[ValueW-1:1]};
      end
      CMD_FORWARD: begin
        ent.op = OP_MOTION;
        ent.lspd = value;
        ent.rspd = value;
      end
      CMD_REVERSE: begin
        ent.op = OP_MOTION;
        ent.lrev = 1'b1;
        ent.rrev = 1'b1;
        ent.lspd = value;
        ent.rspd = value;
      end
      CMD_ACCEL: begin
        ent.op = OP_SPEED_UP;
        ent.lspd = value;
      end
      CMD_DECEL: begin
        ent.op = OP_SLOW_DOWN;
        ent.lspd = value;
      end
      default: ent.op = OP_ERROR;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/rmcc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rmcc_queue #(
  parameter int DEPTH = rmcc_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rmcc_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output rmcc_pkg::entry_t head
);
  import rmcc_pkg::*;

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t            mem [DEPTH];
  logic [IdxW-1:0]   wr_ptr;
  logic [IdxW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full  = (count == CntW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IdxW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IdxW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rmcc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rmcc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rmcc_pkg::SpeedW-1:0] max_speed,
  input  logic                        empty,
  input  rmcc_pkg::entry_t            head,
  output logic                        pop,
  output logic                        res_valid,
  input  logic                        res_ready,
  output rmcc_pkg::result_t           res
);
  import rmcc_pkg::*;

  logic [SpeedW-1:0] left_speed, left_speed_next;
  logic [SpeedW-1:0] right_speed, right_speed_next;
  logic              left_reverse, left_reverse_next;
  logic              right_reverse, right_reverse_next;
  logic              halted, halted_next;
  logic              phase, phase_next;
  logic              load;
  logic              out_free;
  result_t           res_next;

  logic [ValueW:0]   l_sum, r_sum;
  logic [ValueW-1:0] l_diff, r_diff;

  function automatic logic [SpeedW-1:0] clamp(input logic [ValueW:0] s,
                                              input logic [SpeedW-1:0] mx);
    return (s > {2'b00, mx}) ? mx : s[SpeedW-1:0];
  endfunction

  assign out_free = !res_valid || res_ready;

  always_comb begin
    l_sum = {2'b00, left_speed} + {1'b0, head.lspd};
    r_sum = {2'b00, right_speed} + {1'b0, head.lspd};
    l_diff = ({1'b0, left_speed} > head.lspd) ? {1'b0, left_speed} - head.lspd : '0;
    r_diff = ({1'b0, right_speed} > head.lspd) ? {1'b0, right_speed} - head.lspd : '0;
  end

  always_comb begin
    pop                = 1'b0;
    load               = 1'b0;
    phase_next         = phase;
    res_next           = '0;
    left_speed_next    = left_speed;
    right_speed_next   = right_speed;
    left_reverse_next  = left_reverse;
    right_reverse_next = right_reverse;
    halted_next        = halted;
    if (!empty) begin
      unique case (head.op)
        OP_TICK: begin
          // Left command on the first pass, right on the second; the entry
          // stays at the head until both have gone into the output register.
          if (out_free) begin
            load = 1'b1;
            if (!phase) begin
              res_next.speed   = halted ? '0 : left_speed;
              res_next.reverse = halted ? 1'b0 : left_reverse;
              phase_next       = 1'b1;
            end else begin
              res_next.speed        = halted ? '0 : right_speed;
              res_next.reverse      = halted ? 1'b0 : right_reverse;
              res_next.motor_select = 1'b1;
              res_next.last         = 1'b1;
              phase_next            = 1'b0;
              pop                   = 1'b1;
            end
          end
        end
        OP_ERROR: begin
          if (out_free) begin
            load           = 1'b1;
            res_next.error = 1'b1;
            res_next.last  = 1'b1;
            pop            = 1'b1;
          end
        end
        OP_PAUSE: begin
          halted_next = 1'b1;
          pop         = 1'b1;
        end
        OP_RESUME: begin
          halted_next = 1'b0;
          pop         = 1'b1;
        end
        OP_MOTION: begin
          left_reverse_next  = head.lrev;
          right_reverse_next = head.rrev;
          left_speed_next    = clamp({1'b0, head.lspd}, max_speed);
          right_speed_next   = clamp({1'b0, head.rspd}, max_speed);
          pop                = 1'b1;
        end
        OP_SPEED_UP: begin
          left_speed_next  = clamp(l_sum, max_speed);
          right_speed_next = clamp(r_sum, max_speed);
          pop              = 1'b1;
        end
        OP_SLOW_DOWN: begin
          left_speed_next  = clamp({1'b0, l_diff}, max_speed);
          right_speed_next = clamp({1'b0, r_diff}, max_speed);
          pop              = 1'b1;
        end
        default: pop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      phase         <= 1'b0;
      left_speed    <= '0;
      right_speed   <= '0;
      left_reverse  <= 1'b0;
      right_reverse <= 1'b0;
      halted        <= 1'b0;
    end else begin
      res_valid     <= load || (res_valid && !res_ready);
      phase         <= phase_next;
      left_speed    <= left_speed_next;
      right_speed   <= right_speed_next;
      left_reverse  <= left_reverse_next;
      right_reverse <= right_reverse_next;
      halted        <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rover_motor_command_controller_unit.sv @@
// Channel   Dir  Fields (tdata / tuser / tlast)
// s_*       in   tdata: value[7:0]; tuser: cmd[3:0]
// m_*       out  tdata: speed[6:0], reverse[7]; tuser: motor_select[0], error[1]; tlast: last
// cfg_*     in   cfg_index selects the register, cfg_data carries it, cfg_we writes
//
// An event that produces no result is retired by the back end without waiting on the output;
// a tick puts two beats through the output register (left then right), an unknown event one.
// The input side is decoupled by a queue of QUEUE_DEPTH entries, so until it fills events keep
// being taken while results wait on m_tready. Sensor distances in no band never enter the queue.
// Reset is synchronous: queue emptied, set speeds zero, forward, running, registers at
// their defaults. A stalled result holds in the output register.
`timescale 1ns / 1ps
`default_nettype none

module rover_motor_command_controller_unit #(
  parameter int QUEUE_DEPTH = rmcc_pkg::QueueDepth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // value[7:0]
  input  logic [rmcc_pkg::CmdW-1:0]      s_tuser,  // cmd[3:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // speed[6:0], reverse[7]
  output logic [1:0]                     m_tuser,  // motor_select[0], error[1]
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [rmcc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rmcc_pkg::CfgDataW-1:0]  cfg_data
);
  import rmcc_pkg::*;

  cfg_t    cfg;
  logic    enq;
  entry_t  ent;
  logic    full;
  logic    empty;
  logic    pop;
  entry_t  head;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_threshold <= ACCEL_THRESHOLD_RST;
      cfg.decel_reference <= DECEL_REFERENCE_RST;
      cfg.stop_threshold  <= STOP_THRESHOLD_RST;
      cfg.max_speed       <= MAX_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACCEL_THRESHOLD: cfg.accel_threshold <= cfg_data;
        CFG_DECEL_REFERENCE: cfg.decel_reference <= cfg_data;
        CFG_STOP_THRESHOLD:  cfg.stop_threshold  <= cfg_data;
        CFG_MAX_SPEED:       cfg.max_speed       <= cfg_data[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !full;

  rmcc_front u_front (
    .cfg   (cfg),
    .cmd   (s_tuser),
    .value (s_tdata),
    .enq   (enq),
    .ent   (ent)
  );

  rmcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready && enq),
    .push_data (ent),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  rmcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .max_speed (cfg.max_speed),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {res.reverse, res.speed};
  assign m_tuser = {res.error, res.motor_select};
  assign m_tlast = res.last;

endmodule

`default_nettype wire

@@ rtl/core/rmcc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rmcc_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic [1:0] m_tuser,
  input  logic       m_tlast
);

  // A stalled beat keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // An error beat stands alone and carries nothing else.
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && m_tdata == 8'd0)
    else $error("malformed error beat");

  // Only the left command of a tick is not the final beat.
  a_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tuser[0] && !m_tuser[1])
    else $error("non-final beat is not a left command");

  // The right command follows the left one straight after it is taken.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser[0] && !m_tuser[1] && m_tlast)
    else $error("right command did not follow the left one");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind rover_motor_command_controller_unit rmcc_checker u_rmcc_checker (.*);

`default_nettype wire

@@ dv/rover_motor_command_controller_unit_test.sv @@
`timescale 1ns / 1ps

module rover_motor_command_controller_unit_test;
  import rmcc_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNKNOWN_LO = 4'd10;
  localparam logic [CmdW-1:0] CMD_UNKNOWN_HI = 4'd15;
  localparam int IdleSettle = 16;
  localparam int DrainLimit = 20000;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;   // value[7:0]
  logic [CmdW-1:0]     s_tuser;   // cmd[3:0]
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;   // speed[6:0], reverse[7]
  logic [1:0]          m_tuser;   // motor_select[0], error[1]
  logic                m_tlast;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  rover_motor_command_controller_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Register copies and motor state as the controller should hold them.
  logic [ValueW-1:0] cfg_accel = ACCEL_THRESHOLD_RST;
  logic [ValueW-1:0] cfg_ref   = DECEL_REFERENCE_RST;
  logic [ValueW-1:0] cfg_stop  = STOP_THRESHOLD_RST;
  logic [SpeedW-1:0] cfg_max   = MAX_SPEED_RST;
  logic [SpeedW-1:0] left_spd  = '0;
  logic [SpeedW-1:0] right_spd = '0;
  logic              left_rev  = 1'b0;
  logic              right_rev = 1'b0;
  logic              paused    = 1'b0;

  result_t expected_cmds[$];
  int errors = 0;
  int events_taken = 0;
  int sink_hold_cycles = 0;
  bit gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [SpeedW-1:0] clamp_speed(input int s);
    return (s > int'(cfg_max)) ? cfg_max : 7'(s);
  endfunction

  function automatic logic [7:0] near_value(input logic [7:0] centre);
    int x;
    x = int'($urandom_range(0, 4)) - 2 + int'(centre);
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return 8'(x);
  endfunction

  task automatic queue_cmd(input logic [SpeedW-1:0] spd, input logic sel, input logic rev,
                           input logic err, input logic fin);
    result_t r;
    r.speed = spd;
    r.motor_select = sel;
    r.reverse = rev;
    r.error = err;
    r.last = fin;
    expected_cmds.push_back(r);
  endtask

  task automatic steer(input logic lrev, input int lspd, input logic rrev, input int rspd);
    left_rev = lrev;
    right_rev = rrev;
    left_spd = clamp_speed(lspd);
    right_spd = clamp_speed(rspd);
  endtask

  task automatic speed_up(input int amount);
    left_spd = clamp_speed(int'(left_spd) + amount);
    right_spd = clamp_speed(int'(right_spd) + amount);
  endtask

  task automatic slow_down(input int amount);
    left_spd = clamp_speed((int'(left_spd) > amount) ? int'(left_spd) - amount : 0);
    right_spd = clamp_speed((int'(right_spd) > amount) ? int'(right_spd) - amount : 0);
  endtask

  // Updates the motor state for one accepted event and queues the commands it emits.
  // acted is low only for a sensor distance that falls in no band.
  task automatic apply_event(input logic [CmdW-1:0] kind, input logic [7:0] v,
                             output bit acted);
    acted = 1'b1;
    case (kind)
      CMD_TICK: begin
        if (paused) begin
          queue_cmd('0, 1'b0, 1'b0, 1'b0, 1'b0);
          queue_cmd('0, 1'b1, 1'b0, 1'b0, 1'b1);
        end else begin
          queue_cmd(left_spd, 1'b0, left_rev, 1'b0, 1'b0);
          queue_cmd(right_spd, 1'b1, right_rev, 1'b0, 1'b1);
        end
      end
      CMD_SENSOR: begin
        if (v >= cfg_accel) speed_up((v > cfg_ref) ? int'(v) - int'(cfg_ref) : 0);
        else if (v <= cfg_ref && v >= cfg_stop) slow_down(int'(cfg_ref) - int'(v));
        else if (v < cfg_stop) steer(1'b0, 0, 1'b0, 0);
        else acted = 1'b0;
      end
      CMD_PAUSE:   paused = 1'b1;
      CMD_RESUME:  paused = 1'b0;
      CMD_LEFT:    steer(1'b1, int'(v) / 2, 1'b0, int'(v));
      CMD_RIGHT:   steer(1'b0, int'(v), 1'b1, int'(v) / 2);
      CMD_FORWARD: steer(1'b0, int'(v), 1'b0, int'(v));
      CMD_REVERSE: steer(1'b1, int'(v), 1'b1, int'(v));
      CMD_ACCEL:   speed_up(int'(v));
      CMD_DECEL:   slow_down(int'(v));
      default:     queue_cmd('0, 1'b0, 1'b0, 1'b1, 1'b1);
    endcase
  endtask

  // Valid is left high after a beat so that the next event follows without a bubble.
  task automatic send_event(input logic [CmdW-1:0] kind, input logic [7:0] v);
    bit acted;
    while (gaps_on && $urandom_range(0, 99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_event(kind, v, acted);
    if (acted) events_taken++;
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (expected_cmds.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (expected_cmds.size() != 0) begin
      $error("%0d motor command beats never arrived", expected_cmds.size());
      errors++;
      expected_cmds.delete();
    end
    // Events with no command may still sit in the queue of the block.
    repeat (IdleSettle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_ACCEL_THRESHOLD: cfg_accel = data;
      CFG_DECEL_REFERENCE: cfg_ref = data;
      CFG_STOP_THRESHOLD:  cfg_stop = data;
      CFG_MAX_SPEED:       cfg_max = data[SpeedW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_registers(input logic [7:0] accel, input logic [7:0] reference_dist,
                                input logic [7:0] stop, input logic [6:0] max_spd);
    wait_idle();
    write_reg(CFG_ACCEL_THRESHOLD, accel);
    write_reg(CFG_DECEL_REFERENCE, reference_dist);
    write_reg(CFG_STOP_THRESHOLD, stop);
    write_reg(CFG_MAX_SPEED, {1'b0, max_spd});
    cfg_we <= 1'b0;
  endtask

  // Result sink: random stalls, or a counted hold-off when one is requested.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        m_tready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        m_tready <= !(gaps_on && $urandom_range(0, 99) < 9);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected motor command beat: tdata %h tuser %b tlast %b",
               m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = expected_cmds.pop_front();
        if (m_tdata[6:0] !== want.speed) begin
          $error("speed: expected %0d, got %0d", want.speed, m_tdata[6:0]);
          errors++;
        end
        if (m_tdata[7] !== want.reverse) begin
          $error("reverse: expected %0d, got %0d", want.reverse, m_tdata[7]);
          errors++;
        end
        if (m_tuser[0] !== want.motor_select) begin
          $error("motor_select: expected %0d, got %0d", want.motor_select, m_tuser[0]);
          errors++;
        end
        if (m_tuser[1] !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, m_tuser[1]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_event(CMD_TICK, 8'd0);
    send_event(CMD_UNKNOWN_HI, 8'd255);
    send_event(CMD_UNKNOWN_LO, 8'd0);
  endtask

  // Speeds beyond the ceiling are clamped; a turn halves the inner wheel.
  task automatic test_motion_events();
    send_event(CMD_FORWARD, 8'd255);
    send_event(CMD_TICK, 8'd0);
    send_event(CMD_REVERSE, 8'd0);
    send_event(CMD_TICK, 8'd0);
    send_event(CMD_LEFT, 8'd255);
    send_event(CMD_TICK, 8'd0);
    send_event(CMD_RIGHT, 8'd201);
    send_event(CMD_TICK, 8'd255);
  endtask

  task automatic test_speed_changes();
    send_event(CMD_ACCEL, 8'd255);
    send_event(CMD_DECEL, 8'd40);
    send_event(CMD_TICK, 8'd0);
    send_event(CMD_DECEL, 8'd255);
    send_event(CMD_TICK, 8'd0);
  endtask

  task automatic test_sensor_bands();
    send_event(CMD_FORWARD, 8'd50);
    send_event(CMD_SENSOR, 8'd30);
    send_event(CMD_SENSOR, 8'd10);
    send_event(CMD_TICK, 8'd0);
    send_event(CMD_SENSOR, 8'd15);
    send_event(CMD_SENSOR, 8'd7);
    send_event(CMD_TICK, 8'd0);
  endtask

  // Motion taken while paused must only show after the resume.
  task automatic test_pause_resume();
    send_event(CMD_PAUSE, 8'd0);
    send_event(CMD_REVERSE, 8'd90);
    send_event(CMD_TICK, 8'd0);
    send_event(CMD_RESUME, 8'd0);
    send_event(CMD_TICK, 8'd0);
  endtask

  // With the accelerate threshold below the reference the increment bottoms out at zero.
  task automatic test_sensor_offset_below_reference();
    load_registers(8'd5, 8'd200, 8'd1, 7'd127);
    send_event(CMD_FORWARD, 8'd60);
    send_event(CMD_SENSOR, 8'd10);
    send_event(CMD_TICK, 8'd0);
    send_event(CMD_SENSOR, 8'd0);
    send_event(CMD_TICK, 8'd0);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    sink_hold_cycles = 300;
    for (int i = 0; i < 24; i++)
      send_event((i % 3 == 0) ? CMD_FORWARD : CMD_TICK, 8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  task automatic test_random_traffic(input int target);
    int start;
    int pick;
    logic [CmdW-1:0] kind;
    logic [7:0] v;
    start = events_taken;
    while (events_taken - start < target) begin
      pick = $urandom_range(0, 99);
      v = 8'($urandom_range(0, 255));
      if (pick < 25) kind = CMD_TICK;
      else if (pick < 45) begin
        kind = CMD_SENSOR;
        case ($urandom_range(0, 3))
          0: v = near_value(cfg_accel);
          1: v = near_value(cfg_ref);
          2: v = near_value(cfg_stop);
          default: ;
        endcase
      end
      else if (pick < 50) kind = CMD_PAUSE;
      else if (pick < 56) kind = CMD_RESUME;
      else if (pick < 63) kind = CMD_LEFT;
      else if (pick < 70) kind = CMD_RIGHT;
      else if (pick < 77) kind = CMD_FORWARD;
      else if (pick < 83) kind = CMD_REVERSE;
      else if (pick < 89) kind = CMD_ACCEL;
      else if (pick < 95) kind = CMD_DECEL;
      else kind = 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
      if ((kind == CMD_ACCEL || kind == CMD_DECEL) && $urandom_range(0, 9) < 7)
        v = 8'($urandom_range(0, 40));
      send_event(kind, v);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_motion_events();
    test_speed_changes();
    test_sensor_bands();
    test_pause_resume();
    test_sensor_offset_below_reference();
    test_output_backpressure();

    load_registers(ACCEL_THRESHOLD_RST, DECEL_REFERENCE_RST, STOP_THRESHOLD_RST,
                   MAX_SPEED_RST);
    test_random_traffic(350);
    load_registers(8'd255, 8'd255, 8'd255, 7'd0);
    test_random_traffic(150);
    load_registers(8'd0, 8'd0, 8'd0, 7'd127);
    test_random_traffic(150);

    // A long stretch with neither side idling.
    load_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    gaps_on = 1'b0;
    test_random_traffic(350);
    gaps_on = 1'b1;

    load_registers(8'($urandom_range(40, 120)), 8'($urandom_range(20, 39)),
                   8'($urandom_range(0, 19)), 7'($urandom_range(30, 127)));
    test_random_traffic(400);

    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
